// File: hdl/sensor_angle_frame_checker_top_macros.svh
// Assertion macros shared by the sensor angle frame checker RTL.
`ifndef SENSOR_ANGLE_FRAME_CHECKER_TOP_MACROS_SVH
`define SENSOR_ANGLE_FRAME_CHECKER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/safc_pkg.sv
package safc_pkg;

    localparam int FRAME_BYTES = 17;
    localparam int COUNT_W     = $clog2(FRAME_BYTES + 1);

    localparam logic [COUNT_W-1:0] FRAME_LEN    = COUNT_W'(FRAME_BYTES);
    localparam logic [COUNT_W-1:0] POS_CMD      = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] ANGLE_FIRST  = COUNT_W'(3);
    localparam logic [COUNT_W-1:0] ANGLE_LAST   = COUNT_W'(14);
    localparam logic [COUNT_W-1:0] POS_ERROR    = COUNT_W'(FRAME_BYTES - 2);
    localparam logic [COUNT_W-1:0] POS_CHECKSUM = COUNT_W'(FRAME_BYTES - 1);

    localparam logic [1:0] OP_BYTE    = 2'd0;
    localparam logic [1:0] OP_POLL    = 2'd1;
    localparam logic [1:0] OP_DISCARD = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SUM  = 2'd1;
    localparam logic [1:0] ST_CMD  = 2'd2;
    localparam logic [1:0] ST_NONE = 2'd3;

    localparam logic [7:0] CMD_RESET = 8'h04;

    // -1000.0 and -2000.0 as single precision
    localparam logic [31:0] SENTINEL_BAD  = 32'hC47A_0000;
    localparam logic [31:0] SENTINEL_NONE = 32'hC4FA_0000;

    typedef logic [31:0] angle_word_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               complete;
        logic [7:0]         sum;
        logic [7:0]         command;
        logic [7:0]         error;
        logic [7:0]         checksum;
        angle_word_t        angle_x;
        angle_word_t        angle_y;
        angle_word_t        angle_z;
    } frame_t;

endpackage

// File: hdl/safc_frame_capture.sv
module safc_frame_capture
    import safc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] data,
    input  logic       clear,
    output frame_t     frame
);

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [7:0]         sum_reg, sum_next;
    logic [7:0]         command_reg;
    logic [7:0]         error_reg;
    logic [7:0]         checksum_reg;
    angle_word_t        angle_reg [3];

    logic               live;
    logic [COUNT_W-1:0] angle_off;
    logic [1:0]         angle_sel;
    logic [4:0]         lane_base;
    logic               angle_we;

    assign live      = take && (count_reg < FRAME_LEN);
    assign angle_off = count_reg - ANGLE_FIRST;
    assign angle_sel = angle_off[3:2];
    assign lane_base = {angle_off[1:0], 3'b000};
    assign angle_we  = live && (count_reg >= ANGLE_FIRST) && (count_reg <= ANGLE_LAST);

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        if (clear)
        begin
            count_next = '0;
            sum_next   = '0;
        end
        else if (live)
        begin
            count_next = count_reg + COUNT_W'(1);
            if ((count_reg >= POS_CMD) && (count_reg <= POS_ERROR))
            begin
                sum_next = sum_reg + data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            sum_reg      <= '0;
            command_reg  <= '0;
            error_reg    <= '0;
            checksum_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            if (live && (count_reg == POS_CMD))
            begin
                command_reg <= data;
            end
            if (live && (count_reg == POS_ERROR))
            begin
                error_reg <= data;
            end
            if (live && (count_reg == POS_CHECKSUM))
            begin
                checksum_reg <= data;
            end
        end
    end

    // little-endian byte lanes of the three angle words
    always_ff @(posedge clk)
    begin
        if (angle_we)
        begin
            angle_reg[angle_sel][lane_base +: 8] <= data;
        end
    end

    assign frame.count    = count_reg;
    assign frame.complete = (count_reg == FRAME_LEN);
    assign frame.sum      = sum_reg;
    assign frame.command  = command_reg;
    assign frame.error    = error_reg;
    assign frame.checksum = checksum_reg;
    assign frame.angle_x  = angle_reg[0];
    assign frame.angle_y  = angle_reg[1];
    assign frame.angle_z  = angle_reg[2];

endmodule

// File: hdl/sensor_angle_frame_checker_top.sv
// Sensor angle frame checker.
// Input channel (in_valid / in_stall): one transaction per operation: a received
// byte, a poll, or a discard of the partial frame. Bytes build a 17-byte frame.
// Output channel (out_valid / out_stall): one transaction per poll only, with the
// three raw angle words (or sentinels), status, sensor error and angles_valid.
// Config channel (cfg_valid / cfg_ready / cfg_data): expected command byte,
// always ready; write it only while the block is idle.
// Poll path: a poll transaction waits in the input register until the result
// register is free, then loads the result register, which raises out_valid.
// Throughput: one transaction per cycle while in_stall is low, set by the
// frame update between the two registers.
// Reset: frame count and checksum clear, expected command returns to 0x04,
// no result is pending.
// When the receiver stalls, the result is held; byte and discard transactions
// keep flowing, and a second poll waits in the input register, which then
// stalls the input channel until the result register frees up.
`include "sensor_angle_frame_checker_top_macros.svh"

module sensor_angle_frame_checker_top
    import safc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] angle_x_bits,
    output logic [31:0] angle_y_bits,
    output logic [31:0] angle_z_bits,
    output logic [1:0]  status,
    output logic [7:0]  sensor_error,
    output logic        angles_valid,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    logic       s1_valid_reg, s1_valid_next;
    logic [1:0] s1_op_reg;
    logic [7:0] s1_byte_reg;
    logic [7:0] expected_command_reg;

    logic        out_valid_reg, out_valid_next;
    angle_word_t x_reg, y_reg, z_reg;
    angle_word_t x_next, y_next, z_next;
    logic [1:0]  status_reg, status_next;
    logic [7:0]  error_reg, error_next;
    logic        angles_valid_reg, angles_valid_next;

    frame_t frame;
    logic   in_accept;
    logic   out_free;
    logic   is_poll;
    logic   consume;
    logic   poll_fire;
    logic   frame_clear;
    logic   byte_take;

    assign out_free  = !out_valid_reg || !out_stall;
    assign is_poll   = (s1_op_reg == OP_POLL);
    assign consume   = s1_valid_reg && (!is_poll || out_free);
    assign poll_fire = consume && is_poll;
    assign in_stall  = s1_valid_reg && !consume;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign byte_take   = consume && (s1_op_reg == OP_BYTE);
    // a poll on a complete frame consumes it, whatever the verdict
    assign frame_clear = consume && ((s1_op_reg == OP_DISCARD) || (is_poll && frame.complete));

    safc_frame_capture u_capture (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (byte_take),
        .data  (s1_byte_reg),
        .clear (frame_clear),
        .frame (frame)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (consume)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (poll_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        x_next            = SENTINEL_BAD;
        y_next            = SENTINEL_BAD;
        z_next            = SENTINEL_BAD;
        status_next       = ST_OK;
        error_next        = '0;
        angles_valid_next = 1'b0;
        if (!frame.complete)
        begin
            x_next      = SENTINEL_NONE;
            y_next      = SENTINEL_NONE;
            z_next      = SENTINEL_NONE;
            status_next = ST_NONE;
        end
        else if (frame.command != expected_command_reg)
        begin
            status_next = ST_CMD;
        end
        else if (frame.sum != frame.checksum)
        begin
            status_next = ST_SUM;
        end
        else
        begin
            x_next            = frame.angle_x;
            y_next            = frame.angle_y;
            z_next            = frame.angle_z;
            error_next        = frame.error;
            angles_valid_next = (frame.error == 8'h00);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
            expected_command_reg <= CMD_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                expected_command_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg   <= operation;
            s1_byte_reg <= rx_byte;
        end
        if (poll_fire)
        begin
            x_reg            <= x_next;
            y_reg            <= y_next;
            z_reg            <= z_next;
            status_reg       <= status_next;
            error_reg        <= error_next;
            angles_valid_reg <= angles_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign angle_x_bits = x_reg;
    assign angle_y_bits = y_reg;
    assign angle_z_bits = z_reg;
    assign status       = status_reg;
    assign sensor_error = error_reg;
    assign angles_valid = angles_valid_reg;

    `ASSERT_IMPLY(a_valid_implies_ok, clk, rst_n, out_valid && angles_valid,
        (status == ST_OK) && (sensor_error == 8'h00))
    `ASSERT_IMPLY(a_error_only_on_ok, clk, rst_n, out_valid && (status != ST_OK),
        (sensor_error == 8'h00) && !angles_valid)
    `ASSERT_NEXT(a_poll_gives_result, clk, rst_n, poll_fire, out_valid_reg)
    `ASSERT_IMPLY(a_count_bounded, clk, rst_n, 1'b1, frame.count <= FRAME_LEN)

endmodule
